// ----- hw/rtl/e2q_pkg.sv -----
// Shared constants and types for the Euler-to-quaternion pipeline.
package e2q_pkg;

   localparam int CordicSteps = 16;
   localparam int CordicW = 20;
   localparam logic signed [CordicW-1:0] CordicGain = 20'sd39797;
   localparam logic signed [CordicW-1:0] HalfPiQ16 = 20'sd102944;
   localparam logic signed [CordicW-1:0] PiQ16 = 20'sd205887;
   localparam logic signed [15:0] QOne = 16'sd16384;

   typedef logic signed [CordicW-1:0] cordic_word_type;

   typedef struct packed {
      cordic_word_type x;
      cordic_word_type y;
      cordic_word_type z;
      logic flip;
   } cordic_lane_type;

   function automatic cordic_word_type atan_lookup(input logic [3:0] idx);
      cordic_word_type r;
      r = '0;
      case (idx)
         4'd0: r = 20'sd51472;
         4'd1: r = 20'sd30386;
         4'd2: r = 20'sd16055;
         4'd3: r = 20'sd8150;
         4'd4: r = 20'sd4091;
         4'd5: r = 20'sd2047;
         4'd6: r = 20'sd1024;
         4'd7: r = 20'sd512;
         4'd8: r = 20'sd256;
         4'd9: r = 20'sd128;
         4'd10: r = 20'sd64;
         4'd11: r = 20'sd32;
         4'd12: r = 20'sd16;
         4'd13: r = 20'sd8;
         4'd14: r = 20'sd4;
         4'd15: r = 20'sd2;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ----- hw/rtl/euler_to_quaternion_unit.sv -----
// Euler ZYX angles to unit quaternion, deep pipeline with CORDIC and multiply stages.
//
//   channel | direction | ports
//   req     | in        | req_valid, req_stall, req_roll/pitch/yaw_angle
//   rsp     | out       | rsp_valid, rsp_stall, rsp_quat_w/x/y/z
//
// The pipeline is one range-fold stage, sixteen CORDIC stages (one
// micro-rotation each), then five stages: sign fix, pitch x yaw multiply,
// roll multiply, sum with rounding offset, shift/saturate into the output
// register. One beat enters per cycle unless stalled. A stall on rsp while the output
// register holds a beat freezes the whole pipeline; req_stall is high only while the
// output register holds a beat that has not been taken. Reset clears valid bits only.
module euler_to_quaternion_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_roll_angle,
   input  logic signed [15:0] req_pitch_angle,
   input  logic signed [15:0] req_yaw_angle,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_quat_w,
   output logic signed [15:0] rsp_quat_x,
   output logic signed [15:0] rsp_quat_y,
   output logic signed [15:0] rsp_quat_z
);

   localparam int Stages = e2q_pkg::CordicSteps;
   localparam int Depth = Stages + 6;

   logic [Depth-1:0] vld_ff;
   logic advance;

   // Pipeline moves whenever the final register is empty or being drained.
   assign advance = !(vld_ff[Depth-1] && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = vld_ff[Depth-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[Depth-2:0], req_valid};
      end
   end

   // fold stage
   e2q_pkg::cordic_lane_type lane_ff [0:Stages][0:2];
   logic signed [15:0] ang [0:2];
   assign ang[0] = req_roll_angle;
   assign ang[1] = req_pitch_angle;
   assign ang[2] = req_yaw_angle;

   for (genvar a = 0; a < 3; a++) begin : g_axis
      e2q_pkg::cordic_lane_type fold_in;
      always_comb begin
         e2q_pkg::cordic_word_type z;
         z = e2q_pkg::cordic_word_type'({{2{ang[a][15]}}, ang[a], 2'b00});
         fold_in.x = e2q_pkg::CordicGain;
         fold_in.y = '0;
         fold_in.flip = 1'b0;
         if (z > e2q_pkg::HalfPiQ16) begin
            z = z - e2q_pkg::PiQ16;
            fold_in.flip = 1'b1;
         end else if (z < -e2q_pkg::HalfPiQ16) begin
            z = z + e2q_pkg::PiQ16;
            fold_in.flip = 1'b1;
         end
         fold_in.z = z;
      end
      always_ff @(posedge clock) begin
         if (advance) lane_ff[0][a] <= fold_in;
      end

      for (genvar i = 0; i < Stages; i++) begin : g_step
         e2q_pkg::cordic_lane_type step_in;
         always_comb begin
            e2q_pkg::cordic_lane_type c;
            e2q_pkg::cordic_word_type dx;
            e2q_pkg::cordic_word_type dy;
            e2q_pkg::cordic_word_type at;
            c = lane_ff[i][a];
            dx = c.y >>> i;
            dy = c.x >>> i;
            at = e2q_pkg::atan_lookup(4'(i));
            step_in = c;
            if (!c.z[e2q_pkg::CordicW-1]) begin
               step_in.x = c.x - dx;
               step_in.y = c.y + dy;
               step_in.z = c.z - at;
            end else begin
               step_in.x = c.x + dx;
               step_in.y = c.y - dy;
               step_in.z = c.z + at;
            end
         end
         always_ff @(posedge clock) begin
            if (advance) lane_ff[i+1][a] <= step_in;
         end
      end
   end

   // apply flip: cos/sin at 18 bits signed
   logic signed [17:0] cs_ff [0:2];
   logic signed [17:0] sn_ff [0:2];
   for (genvar a = 0; a < 3; a++) begin : g_flip
      always_ff @(posedge clock) begin
         if (advance) begin
            if (lane_ff[Stages][a].flip) begin
               cs_ff[a] <= 18'(-lane_ff[Stages][a].x);
               sn_ff[a] <= 18'(-lane_ff[Stages][a].y);
            end else begin
               cs_ff[a] <= 18'(lane_ff[Stages][a].x);
               sn_ff[a] <= 18'(lane_ff[Stages][a].y);
            end
         end
      end
   end

   // pitch x yaw products (Q.32), roll carried alongside
   logic signed [35:0] cpcy_ff, spsy_ff, cpsy_ff, spcy_ff;
   logic signed [17:0] cr_ff, sr_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         cpcy_ff <= cs_ff[1] * cs_ff[2];
         spsy_ff <= sn_ff[1] * sn_ff[2];
         cpsy_ff <= cs_ff[1] * sn_ff[2];
         spcy_ff <= sn_ff[1] * cs_ff[2];
         cr_ff <= cs_ff[0];
         sr_ff <= sn_ff[0];
      end
   end

   // roll products (Q.48)
   logic signed [53:0] p_ff [0:7];
   always_ff @(posedge clock) begin
      if (advance) begin
         p_ff[0] <= cr_ff * cpcy_ff;
         p_ff[1] <= sr_ff * spsy_ff;
         p_ff[2] <= sr_ff * cpcy_ff;
         p_ff[3] <= cr_ff * spsy_ff;
         p_ff[4] <= cr_ff * spcy_ff;
         p_ff[5] <= sr_ff * cpsy_ff;
         p_ff[6] <= cr_ff * cpsy_ff;
         p_ff[7] <= sr_ff * spcy_ff;
      end
   end

   // sums plus rounding offset
   logic signed [54:0] sum_ff [0:3];
   localparam logic signed [54:0] RoundBias = 55'sd1 <<< 33;
   always_ff @(posedge clock) begin
      if (advance) begin
         sum_ff[0] <= 55'(p_ff[0]) + 55'(p_ff[1]) + RoundBias;
         sum_ff[1] <= 55'(p_ff[2]) - 55'(p_ff[3]) + RoundBias;
         sum_ff[2] <= 55'(p_ff[4]) + 55'(p_ff[5]) + RoundBias;
         sum_ff[3] <= 55'(p_ff[6]) - 55'(p_ff[7]) + RoundBias;
      end
   end

   // shift and saturate into the output register
   logic signed [15:0] q_ff [0:3];
   for (genvar k = 0; k < 4; k++) begin : g_out
      logic signed [20:0] sh;
      logic signed [15:0] q_in;
      assign sh = 21'(sum_ff[k] >>> 34);
      always_comb begin
         if (sh > 21'(e2q_pkg::QOne)) q_in = e2q_pkg::QOne;
         else if (sh < -21'(e2q_pkg::QOne)) q_in = -e2q_pkg::QOne;
         else q_in = 16'(sh);
      end
      always_ff @(posedge clock) begin
         if (advance) q_ff[k] <= q_in;
      end
   end

   assign rsp_quat_w = q_ff[0];
   assign rsp_quat_x = q_ff[1];
   assign rsp_quat_y = q_ff[2];
   assign rsp_quat_z = q_ff[3];

endmodule

// ----- hw/rtl/e2q_checker.sv -----
// Port-level checks for the Euler-to-quaternion unit, and its bind.
module e2q_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [15:0] rsp_quat_w,
   input logic signed [15:0] rsp_quat_x,
   input logic signed [15:0] rsp_quat_y,
   input logic signed [15:0] rsp_quat_z
);

   a_stall_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req stalled without a blocked rsp beat");

   a_w_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_quat_w <= 16'sd16384 && rsp_quat_w >= -16'sd16384))
      else $error("quat_w out of range");

   a_xyz_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_quat_x <= 16'sd16384 && rsp_quat_x >= -16'sd16384 &&
                     rsp_quat_y <= 16'sd16384 && rsp_quat_y >= -16'sd16384 &&
                     rsp_quat_z <= 16'sd16384 && rsp_quat_z >= -16'sd16384))
      else $error("quat vector part out of range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_quat_w)))
      else $error("stalled rsp beat changed");

endmodule

bind euler_to_quaternion_unit e2q_checker u_e2q_checker (.*);

// ----- dv/testbench.sv -----
// Self-checking testbench for the Euler-to-quaternion pipeline.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ItemCount  = 1950;
   localparam int CycleLimit = 200000;
   localparam int DrainWait  = 40;

   typedef struct {
      logic signed [15:0] w;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } quat_type;

   class quat_scoreboard;
      quat_type pending_quats[$];
      int       mismatches = 0;

      // Half angle arrives as raw Q2.14; returns cos and sin in Q.16.
      function automatic void half_sin_cos(input logic signed [15:0] raw,
                                           output longint c, output longint s);
         longint ang, cx, sy, dx, dy;
         bit     flip;
         ang = longint'(raw) * 4;
         cx = e2q_pkg::CordicGain;
         sy = 0;
         flip = 0;
         if (ang > e2q_pkg::HalfPiQ16) begin
            ang -= e2q_pkg::PiQ16;
            flip = 1;
         end else if (ang < -e2q_pkg::HalfPiQ16) begin
            ang += e2q_pkg::PiQ16;
            flip = 1;
         end
         for (int i = 0; i < e2q_pkg::CordicSteps; i++) begin
            dx = sy >>> i;
            dy = cx >>> i;
            if (ang >= 0) begin
               cx -= dx;
               sy += dy;
               ang -= e2q_pkg::atan_lookup(4'(i));
            end else begin
               cx += dx;
               sy -= dy;
               ang += e2q_pkg::atan_lookup(4'(i));
            end
         end
         c = flip ? -cx : cx;
         s = flip ? -sy : sy;
      endfunction

      // Q.48 to Q1.14, round half up, clamp to +/-1.0.
      function automatic logic signed [15:0] round_q14(input longint v);
         longint q;
         q = (v + (longint'(1) <<< 33)) >>> 34;
         if (q > e2q_pkg::QOne) q = e2q_pkg::QOne;
         if (q < -e2q_pkg::QOne) q = -e2q_pkg::QOne;
         return 16'(q);
      endfunction

      function void note_angles(input logic signed [15:0] roll,
                                input logic signed [15:0] pitch,
                                input logic signed [15:0] yaw);
         longint   cr, sr, cp, sp, cy, sy;
         quat_type q;
         half_sin_cos(roll, cr, sr);
         half_sin_cos(pitch, cp, sp);
         half_sin_cos(yaw, cy, sy);
         q.w = round_q14(cr * cp * cy + sr * sp * sy);
         q.x = round_q14(sr * cp * cy - cr * sp * sy);
         q.y = round_q14(cr * sp * cy + sr * cp * sy);
         q.z = round_q14(cr * cp * sy - sr * sp * cy);
         pending_quats.insert(pending_quats.size(), q);
      endfunction

      function void check_quat(input quat_type got);
         quat_type exp_q;
         if (pending_quats.size() == 0) begin
            $error("unexpected result beat w=%0d x=%0d y=%0d z=%0d",
                   got.w, got.x, got.y, got.z);
            mismatches++;
            return;
         end
         exp_q = pending_quats.pop_front();
         if (got.w !== exp_q.w) begin
            $error("quat_w expected %0d actual %0d", exp_q.w, got.w);
            mismatches++;
         end
         if (got.x !== exp_q.x) begin
            $error("quat_x expected %0d actual %0d", exp_q.x, got.x);
            mismatches++;
         end
         if (got.y !== exp_q.y) begin
            $error("quat_y expected %0d actual %0d", exp_q.y, got.y);
            mismatches++;
         end
         if (got.z !== exp_q.z) begin
            $error("quat_z expected %0d actual %0d", exp_q.z, got.z);
            mismatches++;
         end
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic signed [15:0] req_roll_angle = '0;
   logic signed [15:0] req_pitch_angle = '0;
   logic signed [15:0] req_yaw_angle = '0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic signed [15:0] rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z;

   quat_scoreboard quat_board = new();
   int             send_idle_pct = 26;
   int             recv_stall_pct = 83;
   int             cycle_count = 0;

   euler_to_quaternion_unit dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Mismatches found");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_stall <= !reset && ($urandom_range(99) < recv_stall_pct);

   always @(posedge clock) begin
      quat_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.w = rsp_quat_w;
         got.x = rsp_quat_x;
         got.y = rsp_quat_y;
         got.z = rsp_quat_z;
         quat_board.check_quat(got);
      end
   end

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_angles(input logic signed [15:0] roll,
                              input logic signed [15:0] pitch,
                              input logic signed [15:0] yaw);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_valid = 1;
      req_roll_angle = roll;
      req_pitch_angle = pitch;
      req_yaw_angle = yaw;
      do @(posedge clock); while (req_stall);
      quat_board.note_angles(roll, pitch, yaw);
      @(negedge clock);
   endtask

   function automatic logic signed [15:0] pick_angle();
      case ($urandom_range(3))
         0: return 16'($urandom_range(25746, 25726));
         1: return -16'($urandom_range(25746, 25726));
         2: return 16'($urandom_range(4000)) - 16'sd2000;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic signed [15:0] edge_angles[8];
      edge_angles = '{16'sd0, 16'sh7fff, -16'sh8000, 16'sd25736, 16'sd25737,
                      -16'sd25736, -16'sd25737, 16'sd12868};
      repeat (5) @(posedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed: zero, extremes, quarter-turn fold edges per axis; all-axis extremes.
      for (int i = 0; i < 8; i++) send_angles(edge_angles[i], 16'sd0, 16'sd0);
      for (int i = 1; i < 8; i++) send_angles(16'sd0, edge_angles[i], 16'sd0);
      for (int i = 1; i < 8; i++) send_angles(16'sd0, 16'sd0, edge_angles[i]);
      send_angles(16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_angles(-16'sh8000, -16'sh8000, -16'sh8000);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 83 : 0;
         recv_stall_pct = (phase == 0) ? 83 : (phase == 1) ? 26 : 0;
         for (int n = 0; n < ItemCount / 3; n++)
            send_angles(pick_angle(), pick_angle(), pick_angle());
      end
      req_valid = 0;

      while (quat_board.pending_quats.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
      if (quat_board.mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
